// ===== rtl/exclusive_selection_set_core_macros.svh =====
// Assertion macros used by the top RTL file of the selection set core.
// Each macro reports through $error and is empty in synthesis builds.
`ifndef EXCLUSIVE_SELECTION_SET_CORE_MACROS_SVH
`define EXCLUSIVE_SELECTION_SET_CORE_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold on every clock edge out of reset.
`define ESS_ASSERT_HOLD(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold on the same edge.
`define ESS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold on the next edge.
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ESS_ASSERT_HOLD(label, cond, msg)
`define ESS_ASSERT_SAME(label, ante, cons, msg)
`define ESS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/ess_pkg.sv =====
package ess_pkg;

	// Sizing of the set.
	localparam int CAPACITY = 256;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_W     = 64;
	localparam int MODE_W   = 4;
	localparam int POS_W    = 8;
	localparam int ENT_W    = 9;

	// Grouping of the registered reduction tree.
	localparam int GRP  = 16;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// Request codes.
	localparam logic [MODE_W-1:0] MODE_QUERY   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ADD     = 4'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SELECT  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_CLR_SEL = 4'd4;
	localparam logic [MODE_W-1:0] MODE_NEXT    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_PREV    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_GET_AT  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLR_CHG = 4'd8;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic             cmp;
		logic             add;
		logic             shift;
		logic [ID_W-1:0]  item_id;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] pick_idx;
		logic [IDX_W-1:0] rm_idx;
	} cell_ctl_t;

	// What one cell contributes to the reduction tree.
	typedef struct packed {
		logic             match;
		logic [IDX_W-1:0] midx;
		logic             pick;
		logic [ID_W-1:0]  pid;
	} tap_t;

endpackage

// ===== rtl/ess_cell.sv =====
// One slot of the ID list. It holds one ID, compares it with the request,
// and takes its upper neighbour's ID when the list closes a gap.
module ess_cell import ess_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] index,
	input  cell_ctl_t        ctl,
	input  logic [ID_W-1:0]  nbr_id,
	output logic [ID_W-1:0]  id,
	output tap_t             tap
);

	logic [ID_W-1:0] id_q;
	logic            match_q;
	logic            pick_q;
	logic            occupied;

	// A slot is live when it lies below the fill count.
	assign occupied = CNT_W'(index) < ctl.cnt;

	// Stored ID: written by an add at the end of the list, or shifted down.
	always_ff @(posedge clk) begin
		if (ctl.add && (CNT_W'(index) == ctl.cnt)) begin
			id_q <= ctl.item_id;
		end else if (ctl.shift && (index >= ctl.rm_idx)) begin
			id_q <= nbr_id;
		end
	end

	// Match and pick flags are captured in the compare cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			pick_q  <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= occupied && (id_q == ctl.item_id);
			pick_q  <= occupied && (CNT_W'(index) == ctl.pick_idx);
		end
	end

	assign id        = id_q;
	assign tap.match = match_q;
	assign tap.midx  = match_q ? index : '0;
	assign tap.pick  = pick_q;
	assign tap.pid   = pick_q ? id_q : '0;

endmodule

// ===== rtl/ess_ortree.sv =====
// Two-stage registered OR tree over the cell taps. At most one cell
// matches and at most one cell is picked, so OR acts as a selector.
module ess_ortree import ess_pkg::*; (
	input  logic clk,
	input  tap_t taps [CAPACITY],
	output tap_t sum
);

	tap_t grp_d  [NGRP];
	tap_t grp_s1 [NGRP];
	tap_t sum_d;
	tap_t sum_s2;

	// First level: one OR per group of cells.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < CAPACITY) begin
					grp_d[g] = tap_t'(grp_d[g] | taps[g * GRP + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// Second level: OR across the group results.
	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_d = tap_t'(sum_d | grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_d;
	end

	assign sum = sum_s2;

endmodule

// ===== rtl/exclusive_selection_set_core.sv =====
// Channel   Direction  Payload
// s_axis    in         request: mode, item_id, position
// m_axis    out        result: ok, value, found, is_chosen, entries, chosen_id,
//                      any_chosen, changed, overflow
//
// Each request passes from acceptance to a loaded result through the compare
// state in the cell row, the states T1 and T2 of the registered OR tree and
// the apply state, which updates the row and the selection registers.
// One request is in flight at a time; s_axis_tready is high only when idle,
// so a new request is accepted only after the last one has been applied.
// A finished result waits in the output register, and the next request may
// be accepted meanwhile; a stalled result holds back only the apply state.
// Reset (arst_n, asynchronous) empties the set and clears the selection.
`include "exclusive_selection_set_core_macros.svh"

module exclusive_selection_set_core import ess_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mode [3:0], item_id [67:4], position [75:68], zero [79:76]
	input  logic [79:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok [0], value [64:1], found [65], is_chosen [66], entries [75:67],
	// chosen_id [139:76], any_chosen [140], changed [141], overflow [142],
	// zero [143]
	output logic [143:0] m_axis_tdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMP   = 3'd1;
	localparam logic [2:0] ST_T1    = 3'd2;
	localparam logic [2:0] ST_T2    = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;

	logic [2:0]        state_q;
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   item_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  sel_idx_q;
	logic              cv_q;
	logic [ID_W-1:0]   choice_q;
	logic              chg_q;
	logic [CNT_W-1:0]  pick_idx_q;
	logic              out_valid_q;
	logic [143:0]      out_data_q;

	logic [CNT_W-1:0]  pick_idx_d;
	logic [CNT_W-1:0]  sel_ext;
	logic              in_fire;
	logic              apply_fire;

	logic              ok_d;
	logic              ovf_d;
	logic [ID_W-1:0]   value_d;
	logic              found_d;
	logic              is_chosen_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              cv_d;
	logic [ID_W-1:0]   choice_d;
	logic              chg_d;
	logic [IDX_W-1:0]  sel_d;
	logic              add_en;
	logic              rm_en;

	cell_ctl_t         ctl;
	tap_t              taps [CAPACITY];
	logic [ID_W-1:0]   ids  [CAPACITY];
	tap_t              sum;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign apply_fire    = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready);

	// Capture of the request payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= s_axis_tdata[3:0];
			item_q <= s_axis_tdata[67:4];
			pos_q  <= s_axis_tdata[75:68];
		end
	end

	// Index of the cell whose ID a next, previous or get-at request returns.
	assign sel_ext = CNT_W'(sel_idx_q);
	always_comb begin
		case (mode_q)
			MODE_NEXT: begin
				if (cv_q && (CNT_W'(sel_ext + CNT_W'(1)) < cnt_q)) begin
					pick_idx_d = CNT_W'(sel_ext + CNT_W'(1));
				end else begin
					pick_idx_d = '0;
				end
			end
			MODE_PREV: begin
				if (!cv_q || (sel_idx_q == '0)) begin
					pick_idx_d = CNT_W'(cnt_q - CNT_W'(1));
				end else begin
					pick_idx_d = CNT_W'(sel_ext - CNT_W'(1));
				end
			end
			MODE_GET_AT: pick_idx_d = CNT_W'(pos_q);
			default:     pick_idx_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			pick_idx_q <= pick_idx_d;
		end
	end

	// Control broadcast to the cell row.
	assign ctl.cmp      = (state_q == ST_CMP);
	assign ctl.add      = apply_fire && add_en;
	assign ctl.shift    = apply_fire && rm_en;
	assign ctl.item_id  = item_q;
	assign ctl.cnt      = cnt_q;
	assign ctl.pick_idx = pick_idx_d;
	assign ctl.rm_idx   = sum.midx;

	// Row of cells; on a removal, each cell at or above the removed index takes its upper neighbour's ID.
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ID_W-1:0] nbr;
			if (i == CAPACITY - 1) begin : g_top
				assign nbr = ids[i];
			end else begin : g_mid
				assign nbr = ids[i + 1];
			end
			ess_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.index  (IDX_W'(i)),
				.ctl    (ctl),
				.nbr_id (nbr),
				.id     (ids[i]),
				.tap    (taps[i])
			);
		end
	endgenerate

	ess_ortree u_tree (
		.clk  (clk),
		.taps (taps),
		.sum  (sum)
	);

	// Outcome of the request and the state after it.
	always_comb begin
		ok_d     = 1'b0;
		ovf_d    = 1'b0;
		value_d  = '1;
		found_d  = sum.match;
		cnt_d    = cnt_q;
		cv_d     = cv_q;
		choice_d = choice_q;
		chg_d    = chg_q;
		sel_d    = sel_idx_q;
		add_en   = 1'b0;
		rm_en    = 1'b0;
		case (mode_q)
			MODE_QUERY: begin
				ok_d = 1'b1;
			end
			MODE_CLR_CHG: begin
				ok_d  = 1'b1;
				chg_d = 1'b0;
			end
			MODE_ADD: begin
				if (!sum.match) begin
					if (cnt_q == CAP_CNT) begin
						ovf_d = 1'b1;
					end else begin
						add_en  = 1'b1;
						cnt_d   = CNT_W'(cnt_q + CNT_W'(1));
						ok_d    = 1'b1;
						found_d = 1'b1;
					end
				end
			end
			MODE_REMOVE: begin
				if (sum.match) begin
					rm_en   = 1'b1;
					cnt_d   = CNT_W'(cnt_q - CNT_W'(1));
					ok_d    = 1'b1;
					found_d = 1'b0;
					if (cv_q && (sel_idx_q == sum.midx)) begin
						cv_d     = 1'b0;
						choice_d = '1;
						chg_d    = 1'b1;
					end else if (cv_q && (sum.midx < sel_idx_q)) begin
						sel_d = IDX_W'(sel_idx_q - IDX_W'(1));
					end
				end
			end
			MODE_SELECT: begin
				if (sum.match) begin
					if (!cv_q || (choice_q != item_q)) begin
						chg_d = 1'b1;
					end
					cv_d     = 1'b1;
					choice_d = item_q;
					sel_d    = sum.midx;
					ok_d     = 1'b1;
				end
			end
			MODE_CLR_SEL: begin
				if (cv_q) begin
					cv_d     = 1'b0;
					choice_d = '1;
					chg_d    = 1'b1;
				end
				ok_d = 1'b1;
			end
			MODE_NEXT, MODE_PREV: begin
				if (cnt_q != '0) begin
					value_d = sum.pid;
					if (!cv_q || (choice_q != sum.pid)) begin
						chg_d = 1'b1;
					end
					cv_d     = 1'b1;
					choice_d = sum.pid;
					sel_d    = pick_idx_q[IDX_W-1:0];
					ok_d     = 1'b1;
				end
			end
			MODE_GET_AT: begin
				if (32'(pos_q) < 32'(cnt_q)) begin
					value_d = sum.pid;
					ok_d    = 1'b1;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		is_chosen_d = cv_d && (choice_d == item_q);
	end

	// Sequencer and selection state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sel_idx_q <= '0;
			cv_q      <= 1'b0;
			choice_q  <= '1;
			chg_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP:  state_q <= ST_T1;
				ST_T1:   state_q <= ST_T2;
				ST_T2:   state_q <= ST_APPLY;
				ST_APPLY: begin
					if (apply_fire) begin
						state_q   <= ST_IDLE;
						cnt_q     <= cnt_d;
						sel_idx_q <= sel_d;
						cv_q      <= cv_d;
						choice_q  <= choice_d;
						chg_q     <= chg_d;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: holds a result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_data_q <= {1'b0, ovf_d, chg_d, cv_d, choice_d, ENT_W'(cnt_d),
				is_chosen_d, found_d, value_d, ok_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`ESS_ASSERT_HOLD(a_cnt_range, cnt_q <= CAP_CNT, "fill count beyond capacity")
	`ESS_ASSERT_SAME(a_none_is_minus_one, !cv_q, choice_q == '1,
		"selection register not minus one while nothing is selected")
	`ESS_ASSERT_SAME(a_sel_in_list, cv_q, CNT_W'(sel_idx_q) < cnt_q,
		"selected index lies outside the list")
	`ESS_ASSERT_NEXT(a_accept_to_cmp, in_fire, state_q == ST_CMP,
		"accepted request did not enter the compare cycle")

endmodule
